/* rtl/chtc_pkg.sv */
// ----------------------------------------------------------------------------
// chtc_pkg
// Shared types, constants and the CRC column function for the checked
// humidity / temperature converter.
// ----------------------------------------------------------------------------
package chtc_pkg;

	// Item layouts
	typedef struct packed {
		logic        cmd;         // 0 humidity, 1 temperature
		logic [15:0] raw_word;
		logic [7:0]  check_byte;
	} in_item_t;

	typedef struct packed {
		logic signed [14:0] value;   // hundredths of a percent or a degree
		logic               status;  // 1 on check byte mismatch
	} out_item_t;

	// Measurement kinds
	localparam logic KIND_HUMIDITY    = 1'b0;
	localparam logic KIND_TEMPERATURE = 1'b1;

	// CRC-8, x^8+x^5+x^4+1, zero initial value
	localparam int          CRC_W      = 8;
	localparam int          CRC_MSG_W  = 24;
	localparam logic [7:0]  CRC_POLY   = 8'h31;

	// Scaling
	localparam int          SCALE_SHIFT = 16;
	localparam logic [13:0] HUM_SCALE   = 14'd12500;
	localparam logic [14:0] TEMP_SCALE  = 15'd17572;
	localparam logic [13:0] HUM_OFFSET  = 14'd600;
	localparam logic [13:0] HUM_MAX     = 14'd10000;
	localparam logic [14:0] TEMP_OFFSET = 15'd4685;

	// Remainder of x^pos modulo the generator; one column of the CRC matrix.
	function automatic logic [CRC_W-1:0] crc_column(input int pos);
		logic [CRC_W-1:0] r;
		r = 8'h01;
		for (int i = 0; i < CRC_MSG_W; i++) begin
			if (i < pos) begin
				r = r[CRC_W-1] ? ({r[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {r[CRC_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

/* rtl/chtc_crc.sv */
// ----------------------------------------------------------------------------
// chtc_crc
// Check of the received CRC byte against the raw word: flags a non-zero
// remainder over raw word and check byte.
// ----------------------------------------------------------------------------
module chtc_crc (
	input  logic [15:0] raw_word,
	input  logic [7:0]  check_byte,
	output logic        fail
);
	import chtc_pkg::*;

	logic [CRC_MSG_W-1:0] msg;
	logic [CRC_W-1:0]     rem;

	assign msg = {raw_word, check_byte};

	// The remainder is linear in the message: XOR the column of every set bit.
	always_comb begin
		rem = '0;
		for (int i = 0; i < CRC_MSG_W; i++) begin
			if (msg[i]) begin
				rem = rem ^ crc_column(i);
			end
		end
	end

	assign fail = (rem != '0);

endmodule

/* rtl/chtc_scale.sv */
// ----------------------------------------------------------------------------
// chtc_scale
// Scaling of a raw word to hundredths: clamped humidity or offset
// temperature, selected by the measurement kind.
// ----------------------------------------------------------------------------
module chtc_scale (
	input  logic               cmd,
	input  logic [15:0]        raw_word,
	output logic signed [14:0] value
);
	import chtc_pkg::*;

	logic [29:0]        hum_prod;
	logic [30:0]        temp_prod;
	logic [13:0]        hum_q;
	logic [14:0]        temp_q;
	logic [13:0]        hum_val;
	logic signed [14:0] temp_val;

	assign hum_prod  = 30'(raw_word) * 30'(HUM_SCALE);
	assign temp_prod = 31'(raw_word) * 31'(TEMP_SCALE);
	assign hum_q     = hum_prod[SCALE_SHIFT +: 14];
	assign temp_q    = temp_prod[SCALE_SHIFT +: 15];

	// Saturate humidity to 0..HUM_MAX
	always_comb begin
		priority if (hum_q < HUM_OFFSET) begin
			hum_val = '0;
		end else if (hum_q - HUM_OFFSET > HUM_MAX) begin
			hum_val = HUM_MAX;
		end else begin
			hum_val = hum_q - HUM_OFFSET;
		end
	end

	assign temp_val = $signed(temp_q - TEMP_OFFSET);

	always_comb begin
		unique case (cmd)
			KIND_HUMIDITY: begin
				value = $signed({1'b0, hum_val});
			end
			KIND_TEMPERATURE: begin
				value = temp_val;
			end
			default: begin
				value = '0;
			end
		endcase
	end

endmodule

/* rtl/crc_checked_humidity_temp_convert.sv */
// ----------------------------------------------------------------------------
// crc_checked_humidity_temp_convert
// Checked humidity / temperature conversion: verify the CRC-8 of a sensor
// reading and scale it to hundredths of a percent or of a degree.
// ----------------------------------------------------------------------------
// Each input item is a reading (kind, 16-bit raw word, received check byte)
// and gives exactly one result item. The block takes one item per clock
// while out_ready keeps taking results: the item is held in an input
// register, the CRC-8 (x^8+x^5+x^4+1, zero start) and the constant scaling
// run as one pass of logic, and the result lands in the output register,
// which holds it until out_ready takes it. That pass, a 16 by 14 and a 16
// by 15 bit constant multiply with the subtract and clamp, sets the clock
// figure. While the output register is full and not taken, the input
// register still takes one more item; in_ready falls only when both are
// full. A reading whose check fails gives status 1 and value 0. Humidity is
// clamped to 0..10000; temperature spans -4685..12886. There is no
// configuration and no state beyond the two pipeline registers.
// ----------------------------------------------------------------------------
module crc_checked_humidity_temp_convert (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  chtc_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output chtc_pkg::out_item_t  out_data
);
	import chtc_pkg::*;

	// Input register
	logic     valid_s1;
	in_item_t item_s1;

	// Result register
	logic      valid_s2;
	out_item_t item_s2;

	logic               load_s2;
	logic               crc_fail;
	logic signed [14:0] conv_value;
	out_item_t          result;

	// Advance the result register when it is empty or being emptied; the
	// input register may take a new item when it is empty or moves on too.
	assign load_s2  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the payload; load only on an accepted item
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	chtc_crc u_crc (
		.raw_word   (item_s1.raw_word),
		.check_byte (item_s1.check_byte),
		.fail       (crc_fail)
	);

	chtc_scale u_scale (
		.cmd      (item_s1.cmd),
		.raw_word (item_s1.raw_word),
		.value    (conv_value)
	);

	// Drop the converted value on a check failure
	always_comb begin
		result.status = crc_fail;
		result.value  = crc_fail ? '0 : conv_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			item_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = item_s2;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: checked humidity / temperature converter
// Drives sensor readings through the valid/ready input, predicts each
// conversion (CRC-8 check, scaling, clamp) and compares every result in order.
// ----------------------------------------------------------------------------
module tb_top;
	import chtc_pkg::*;

	// Own copies of the conversion constants
	localparam logic [8:0] CRC_GEN     = 9'h131;   // x^8+x^5+x^4+1
	localparam int         RH_SCALE    = 12500;
	localparam int         RH_OFFSET   = 600;
	localparam int         RH_CEILING  = 10000;
	localparam int         T_SCALE     = 17572;
	localparam int         T_OFFSET    = 4685;
	localparam int         FRAC_SHIFT  = 16;

	// Result status codes
	localparam logic ST_OK       = 1'b0;
	localparam logic ST_CRC_FAIL = 1'b1;

	// Stretch for the long receiver hold-off
	localparam int CHOKE_CYCLES = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;

	in_item_t    pending_readings[$];   // readings waiting for the driver
	out_item_t   due_results[$];        // conversions accepted, result not yet seen

	bit          in_taken = 1'b0;       // item on the input was accepted at the last edge
	bit          quiet_tail = 1'b0;     // no idling on either side from here on
	int          send_gap = 0;
	int          stall_left = 0;
	int          choke_left = 0;
	int          choke_req = 0;
	int          choke_done = 0;
	int          err_cnt = 0;

	crc_checked_humidity_temp_convert u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Remainder of the 24-bit message {raw, check} divided by the generator.
	// Zero means the check byte matches; with check = 0 it gives the byte to send.
	function automatic logic [7:0] crc_residue(input logic [15:0] raw, input logic [7:0] chk);
		logic [23:0] rem;
		rem = {raw, chk};
		for (int i = 23; i >= 8; i--) begin
			if (rem[i]) begin
				rem = rem ^ (24'(CRC_GEN) << (i - 8));
			end
		end
		return rem[7:0];
	endfunction

	// Expected result for one reading
	function automatic out_item_t convert_reading(input in_item_t rd);
		out_item_t   res;
		int unsigned scaled;
		int          v;
		if (crc_residue(rd.raw_word, rd.check_byte) != 8'h00) begin
			res.value  = '0;
			res.status = ST_CRC_FAIL;
			return res;
		end
		if (rd.cmd == KIND_HUMIDITY) begin
			scaled = (32'(rd.raw_word) * RH_SCALE) >> FRAC_SHIFT;
			v = int'(scaled) - RH_OFFSET;
			if (v > RH_CEILING) begin
				v = RH_CEILING;
			end
			if (v < 0) begin
				v = 0;
			end
		end else begin
			scaled = (32'(rd.raw_word) * T_SCALE) >> FRAC_SHIFT;
			v = int'(scaled) - T_OFFSET;
		end
		res.value  = v[14:0];
		res.status = ST_OK;
		return res;
	endfunction

	// Queue a reading; a non-zero flip corrupts the otherwise correct check byte
	task automatic queue_reading(input logic kind, input logic [15:0] raw, input logic [7:0] flip);
		in_item_t rd;
		rd.cmd        = kind;
		rd.raw_word   = raw;
		rd.check_byte = crc_residue(raw, 8'h00) ^ flip;
		pending_readings.push_back(rd);
	endtask

	// Mostly well-formed readings with random content, some broken check bytes,
	// and a share of raw words near the clamp points, the temperature sign change and the extremes
	task automatic queue_random(input int n);
		logic [15:0] raw;
		logic [7:0]  flip;
		in_item_t    rd;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 9))
				0: begin
					raw = 16'($urandom_range(3100, 3200));
				end
				1: begin
					raw = 16'($urandom_range(55500, 55650));
				end
				2: begin
					raw = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3))
						: 16'($urandom_range(65532, 65535));
				end
				3: begin
					raw = 16'($urandom_range(17400, 17550));
				end
				default: begin
					raw = 16'($urandom_range(0, 65535));
				end
			endcase
			case ($urandom_range(0, 9))
				0: begin
					// single bit error in the check byte
					flip = 8'h01 << $urandom_range(0, 7);
				end
				1: begin
					// arbitrary check byte, usually wrong
					rd.cmd        = 1'($urandom_range(0, 1));
					rd.raw_word   = raw;
					rd.check_byte = 8'($urandom_range(0, 255));
					pending_readings.push_back(rd);
					continue;
				end
				default: begin
					flip = 8'h00;
				end
			endcase
			queue_reading(1'($urandom_range(0, 1)), raw, flip);
		end
	endtask

	// Hold until the driver has nothing left and every result has come back
	task automatic wait_drained();
		while (pending_readings.size() != 0 || in_valid || due_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Driver: hold the item until taken, then idle in short bursts or advance
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// hold payload and valid until the handshake
		end else if (send_gap > 0) begin
			send_gap--;
			in_valid <= 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			send_gap = $urandom_range(0, 4);
			in_valid <= 1'b0;
		end else if (pending_readings.size() != 0) begin
			in_data  <= pending_readings.pop_front();
			in_valid <= 1'b1;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (choke_left > 0) begin
			choke_left--;
			out_ready <= 1'b0;
		end else if (choke_req != choke_done) begin
			choke_done = choke_req;
			choke_left = CHOKE_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: check results in order, then predict from accepted readings
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result, value %0d status %0b", $time,
						out_data.value, out_data.status);
					err_cnt++;
				end else begin
					want = due_results.pop_front();
					if (out_data.value !== want.value) begin
						$display("%0t: value mismatch, expected %0d, actual %0d", $time,
							want.value, out_data.value);
						err_cnt++;
					end
					if (out_data.status !== want.status) begin
						$display("%0t: status mismatch, expected %0b, actual %0b", $time,
							want.status, out_data.status);
						err_cnt++;
					end
				end
			end
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				due_results.push_back(convert_reading(in_data));
			end
		end
	end

	// Stimulus and run control
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: humidity clamp edges, temperature sign change, extremes
		queue_reading(KIND_HUMIDITY, 16'd0, 8'h00);
		queue_reading(KIND_HUMIDITY, 16'd1, 8'h00);
		queue_reading(KIND_HUMIDITY, 16'd3145, 8'h00);
		queue_reading(KIND_HUMIDITY, 16'd3146, 8'h00);
		queue_reading(KIND_HUMIDITY, 16'd3152, 8'h00);
		queue_reading(KIND_HUMIDITY, 16'd32768, 8'h00);
		queue_reading(KIND_HUMIDITY, 16'd55574, 8'h00);
		queue_reading(KIND_HUMIDITY, 16'd55575, 8'h00);
		queue_reading(KIND_HUMIDITY, 16'd55581, 8'h00);
		queue_reading(KIND_HUMIDITY, 16'hFFFF, 8'h00);
		queue_reading(KIND_TEMPERATURE, 16'd0, 8'h00);
		queue_reading(KIND_TEMPERATURE, 16'd1, 8'h00);
		queue_reading(KIND_TEMPERATURE, 16'd17473, 8'h00);
		queue_reading(KIND_TEMPERATURE, 16'd17474, 8'h00);
		queue_reading(KIND_TEMPERATURE, 16'd32768, 8'h00);
		queue_reading(KIND_TEMPERATURE, 16'hFFFF, 8'h00);
		// Check failures on both kinds, including a corrupted all-zero reading
		queue_reading(KIND_HUMIDITY, 16'h1234, 8'h01);
		queue_reading(KIND_HUMIDITY, 16'hFFFF, 8'h80);
		queue_reading(KIND_TEMPERATURE, 16'h0000, 8'hFF);
		queue_reading(KIND_TEMPERATURE, 16'hABCD, 8'h10);
		queue_reading(KIND_TEMPERATURE, 16'hFFFF, 8'h5A);

		// Sender pause: let everything come back before the random part
		wait_drained();

		// Random, first block: hold the receiver off while items keep coming
		queue_random(400);
		choke_req++;
		wait_drained();

		// Random, second block, with another long hold-off
		queue_random(380);
		choke_req++;
		while (pending_readings.size() > 0) begin
			@(negedge clk);
		end

		// Tail at full rate on both sides
		quiet_tail = 1'b1;
		queue_random(100);
		wait_drained();
		repeat (8) @(negedge clk);

		if (err_cnt == 0 && due_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/chtc_pkg.sv
rtl/chtc_crc.sv
rtl/chtc_scale.sv
rtl/crc_checked_humidity_temp_convert.sv
test/tb_top.sv
